[design/recent_event_duplicate_filter_unit_macros.svh]
// Assertion macros shared by the filter's RTL.
// Every check runs on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef RECENT_EVENT_DUPLICATE_FILTER_UNIT_MACROS_SVH
`define RECENT_EVENT_DUPLICATE_FILTER_UNIT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define REDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define REDF_ASSERT_NEXT(label, ante, cons, msg) \
    `REDF_ASSERT(label, (ante) |=> (cons), msg)

`endif

[design/redf_pkg.sv]
`default_nettype none

package redf_pkg;

    // Default number of remembered sender and event pairs.
    localparam int DEFAULT_TABLE_DEPTH = 32;

    // One stored pair is the device id above the event id.
    localparam int KEY_W = 32;

    // Reset value of the minimum payload length register.
    localparam logic [7:0] MIN_LEN_RESET = 8'd8;

    // Action codes of a result item.
    localparam logic [1:0] ACT_IGNORE = 2'd0;
    localparam logic [1:0] ACT_REPEAT = 2'd1;
    localparam logic [1:0] ACT_RECORD = 2'd2;

    // One received message.
    typedef struct packed {
        logic        is_event;
        logic [7:0]  payload_len;
        logic [15:0] device_id;
        logic [15:0] event_id;
    } t_in_item;

    // One decision with the acknowledgement ids.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] ack_device;
        logic [15:0] ack_event;
    } t_out_item;

endpackage

`default_nettype wire

[design/redf_pair_ram.sv]
`default_nettype none

module redf_pair_ram
    import redf_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [KEY_W-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [KEY_W-1:0]  o_rdata
);

    // Pair storage, one write port and one registered read port.
    logic [KEY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/recent_event_duplicate_filter_unit.sv]
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_in_item  (t_in_item)
// out       output     o_out_valid/i_out_stall o_out_item (t_out_item)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (min_payload_len)
//
// A counted event scans every filled pair before its result is loaded, an ignored one reads none;
// the pair table has one read port, so the scan reads one pair per cycle.
// One item is in work at a time; o_in_stall is high from accept until the result is loaded.
// Reset is synchronous and clears the fill count, write pointer and control state and sets
// min_payload_len to 8; the table needs no clearing pass, since only filled entries are read.
// A result waits in the output register while the next item is accepted and scanned.
`default_nettype none

`include "recent_event_duplicate_filter_unit_macros.svh"

module recent_event_duplicate_filter_unit
    import redf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_item, n_item;
    logic             r_qual, n_qual;
    logic             r_hit, n_hit;
    logic             r_rd_pend, n_rd_pend;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_wp, n_wp;
    logic [7:0]       r_min_len, n_min_len;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             in_take;
    logic             out_free;
    logic             rd_issue;
    logic             mem_we;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] rd_data;

    assign key      = {r_item.device_id, r_item.event_id};
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_issue = (r_state == S_SCAN) && r_qual && (r_idx < r_fill);
    assign mem_we   = (r_state == S_FINISH) && out_free && r_qual && !r_hit;

    // Reads happen only while scanning and writes only when finishing, so the
    // two never touch the same entry in one cycle.
    redf_pair_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (key),
        .i_re    (rd_issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // Next-state logic of the scan sequencer, the pointers and the output slot.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_qual      = r_qual;
        n_hit       = r_hit || (r_rd_pend && (rd_data == key));
        n_rd_pend   = rd_issue;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_wp        = r_wp;
        n_min_len   = r_min_len;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cfg_valid && o_cfg_ready) begin
            n_min_len = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_item  = i_in_item;
                    n_qual  = i_in_item.is_event && (i_in_item.payload_len >= r_min_len);
                    n_hit   = 1'b0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // The last read's compare happens in the cycle that leaves.
                if (rd_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (!r_qual) begin
                        n_out.action     = ACT_IGNORE;
                        n_out.ack_device = '0;
                        n_out.ack_event  = '0;
                    end else begin
                        n_out.ack_device = r_item.device_id;
                        n_out.ack_event  = r_item.event_id;
                        if (r_hit) begin
                            n_out.action = ACT_REPEAT;
                        end else begin
                            n_out.action = ACT_RECORD;
                            n_wp = (r_wp == LAST_IDX) ? '0 : r_wp + IDX_W'(1);
                            if (r_fill != FULL_CNT) begin
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_fill      <= '0;
            r_wp        <= '0;
            r_min_len   <= MIN_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_fill      <= n_fill;
            r_wp        <= n_wp;
            r_min_len   <= n_min_len;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_qual <= n_qual;
        r_hit  <= n_hit;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // The fill count never passes the table depth.
    `REDF_ASSERT(a_fill_bound, r_fill <= FULL_CNT, "fill count exceeds table depth")
    // A table write and a table read never share a cycle.
    `REDF_ASSERT(a_no_rw_overlap, !(mem_we && rd_issue), "pair table read and write overlap")
    // An ignored message carries zero ids.
    `REDF_ASSERT(a_ignore_zero, (o_out_valid && (o_out_item.action == ACT_IGNORE)) |->
        ((o_out_item.ack_device == 16'd0) && (o_out_item.ack_event == 16'd0)),
        "ignored item has nonzero ids")
    // Recording a new pair advances the fill count unless the table is full.
    `REDF_ASSERT_NEXT(a_fill_step, mem_we && (r_fill != FULL_CNT),
        r_fill == $past(r_fill) + CNT_W'(1), "fill count did not advance on record")

endmodule

`default_nettype wire
